### rtl/ffha_pkg.sv
package ffha_pkg;
  localparam int unsigned MAX_BLOCKS_DEF = 256;
  localparam int unsigned HEADER_BYTES_DEF = 16;
  localparam int unsigned MIN_SPLIT = 16;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned BYTES_W = 25;
  localparam int unsigned REQ_W = 24;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BYTES = 1'd1;
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_NO_MEM = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;
endpackage

### rtl/first_fit_heap_allocator_core.sv
// First-fit heap allocator. The block table (offset, payload size, free bit
// per entry, address order) sits in a memory walked by a small sequencer.
// Commands arrive on s_axis: tuser = cmd, tdata = {request_bytes,
// release_address} from bit 0 up. Each command gives exactly one m_axis
// transfer: tdata = {block_address, status} from bit 0 up. An allocate reads
// and checks entries one at a time until a fit and marks the hit entry taken;
// a split then shifts all following entries up one slot and writes the
// remainder. A free scans the same way, then one compaction pass over the
// table merges runs of free blocks. s_axis_tready is low while a command is
// in work or its result is still waiting. After reset or any configuration
// write the table is one free block; this needs no clearing pass.
module first_fit_heap_allocator_core #(
  parameter int unsigned MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // request_bytes, release_address
  input  logic s_axis_tuser,          // cmd
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [39:0] m_axis_tdata,   // block_address, status
  input  logic cfg_we,
  input  logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ffha_pkg::ADDR_W-1:0] cfg_data
);
  import ffha_pkg::*;

  localparam int unsigned IW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

  typedef struct packed {
    logic [BYTES_W-1:0] off;
    logic [BYTES_W-1:0] size;
    logic               free;
  } ent_t;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RD    = 10'b0000000010,
    S_CHK   = 10'b0000000100,
    S_SHRD  = 10'b0000001000,
    S_SHWR  = 10'b0000010000,
    S_SPLIT = 10'b0000100000,
    S_CRD   = 10'b0001000000,
    S_CCHK  = 10'b0010000000,
    S_CFIN  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state;
  ent_t mem [MAX_BLOCKS];
  ent_t rdata;
  logic [IW-1:0] raddr;
  logic re;

  logic [ADDR_W-1:0] heap_base;
  logic [BYTES_W-1:0] heap_bytes;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;   // scan / shift pointer
  logic [CW-1:0] hit;   // found entry
  logic [CW-1:0] wr_i;  // compaction write slot
  ent_t acc;            // compaction accumulator
  logic cmd;
  logic [BYTES_W-1:0] need;
  logic [ADDR_W-1:0] rel;
  logic [ADDR_W-1:0] out_addr;
  logic [1:0] out_status;
  ent_t found;

  // entry 0 is held in the memory only when written; valid bit covers reset
  logic [BYTES_W-1:0] init_size;
  assign init_size = (heap_bytes >= BYTES_W'(HEADER_BYTES)) ?
                     heap_bytes - BYTES_W'(HEADER_BYTES) : '0;

  logic we;
  logic [IW-1:0] waddr;
  ent_t wdata;
  logic e0_valid;       // cleared on rebuild: entry 0 reads as the initial block

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  logic rd_e0;          // read was of entry 0 while not yet written
  ent_t cur;
  assign cur = rd_e0 ? ent_t'{off: '0, size: init_size, free: 1'b1} : rdata;

  logic [ADDR_W-1:0] cur_pay;
  assign cur_pay = heap_base + ADDR_W'(cur.off) + ADDR_W'(HEADER_BYTES);

  logic [BYTES_W+1:0] split_need;
  assign split_need = (BYTES_W+2)'(need) + (BYTES_W+2)'(HEADER_BYTES + MIN_SPLIT);

  // allocate hit, and whether the hit block is cut in two
  logic fit;
  logic split_ok;
  assign fit = (cmd == CMD_ALLOC) && cur.free && (cur.size >= need);
  assign split_ok = ((BYTES_W+2)'(cur.size) >= split_need) && (count < CW'(MAX_BLOCKS));

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata = {6'd0, out_status, out_addr};

  always_comb begin
    re = 1'b0; raddr = idx[IW-1:0];
    we = 1'b0; waddr = idx[IW-1:0]; wdata = cur;
    unique case (state) inside
      S_RD, S_SHRD, S_CRD: re = 1'b1;
      // hit entry is never moved by the shift, so it is taken right here
      S_CHK: if (fit) begin
        we = 1'b1;
        wdata = ent_t'{off: cur.off, size: split_ok ? need : cur.size, free: 1'b0};
      end
      S_SHWR: begin
        we = 1'b1; waddr = IW'(idx + CW'(1)); wdata = cur;
      end
      // remainder lands in the slot just opened above the hit entry
      S_SPLIT: begin
        we = 1'b1; waddr = idx[IW-1:0];
        wdata = ent_t'{off: found.off + BYTES_W'(HEADER_BYTES) + need,
                       size: found.size - need - BYTES_W'(HEADER_BYTES),
                       free: 1'b1};
      end
      S_CCHK: if (idx != '0 && !(acc.free && (cur.free || idx == hit))) begin
        we = 1'b1; waddr = wr_i[IW-1:0]; wdata = acc;
      end
      S_CFIN: begin
        we = 1'b1; waddr = wr_i[IW-1:0]; wdata = acc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; heap_base <= '0; heap_bytes <= BYTES_W'(65536);
      count <= CW'(1); e0_valid <= 1'b0; rd_e0 <= 1'b0;
    end else begin
      if (we && waddr == '0) e0_valid <= 1'b1;
      if (re) rd_e0 <= (raddr == '0) && !(e0_valid || (we && waddr == '0));
      if (cfg_we && (cfg_index == REG_HEAP_BASE || cfg_index == REG_HEAP_BYTES)) begin
        if (cfg_index == REG_HEAP_BASE) heap_base <= cfg_data;
        else heap_bytes <= cfg_data[BYTES_W-1:0];
        count <= CW'(1); e0_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (s_axis_tvalid) begin
          cmd <= s_axis_tuser;
          need <= BYTES_W'((s_axis_tdata[REQ_W-1:0] + 25'd7) & ~25'd7);
          rel <= s_axis_tdata[REQ_W+ADDR_W-1:REQ_W];
          idx <= '0; out_addr <= '0;
          if (s_axis_tuser == CMD_ALLOC ? s_axis_tdata[REQ_W-1:0] == '0
                                        : s_axis_tdata[REQ_W+ADDR_W-1:REQ_W] == '0) begin
            out_status <= ST_IGNORED; state <= S_OUT;
          end else state <= S_RD;
        end
        S_RD: state <= S_CHK;
        S_CHK: begin
          if (cmd == CMD_ALLOC) begin
            if (fit) begin
              out_addr <= cur_pay; out_status <= ST_DONE;
              found <= cur; hit <= idx;
              if (split_ok) begin
                idx <= count - CW'(1); state <= S_SHRD;
              end else state <= S_OUT;
            end else if (idx + CW'(1) >= count) begin
              out_status <= ST_NO_MEM; state <= S_OUT;
            end else begin
              idx <= idx + CW'(1); state <= S_RD;
            end
          end else begin
            if (cur_pay == rel) begin
              out_status <= ST_DONE; hit <= idx; idx <= '0; wr_i <= '0;
              state <= S_CRD;
            end else if (idx + CW'(1) >= count) begin
              out_status <= ST_UNKNOWN; state <= S_OUT;
            end else begin
              idx <= idx + CW'(1); state <= S_RD;
            end
          end
        end
        // move entries idx..hit+1 up one slot, top first
        S_SHRD: begin
          if (idx == hit) begin
            idx <= hit + CW'(1); state <= S_SPLIT;
          end else state <= S_SHWR;
        end
        S_SHWR: begin
          idx <= idx - CW'(1); state <= S_SHRD;
        end
        S_SPLIT: begin
          count <= count + CW'(1); state <= S_OUT;
        end
        S_CRD: state <= S_CCHK;
        S_CCHK: begin
          if (idx == '0) begin
            acc <= ent_t'{off: cur.off, size: cur.size, free: cur.free | (hit == '0)};
          end else if (acc.free && (cur.free || idx == hit)) begin
            acc.size <= acc.size + BYTES_W'(HEADER_BYTES) + cur.size;
          end else begin
            wr_i <= wr_i + CW'(1);
            acc <= ent_t'{off: cur.off, size: cur.size, free: cur.free | (idx == hit)};
          end
          if (idx + CW'(1) >= count) state <= S_CFIN;
          else begin
            idx <= idx + CW'(1); state <= S_CRD;
          end
        end
        S_CFIN: begin
          count <= wr_i + CW'(1); state <= S_OUT;
        end
        S_OUT: if (m_axis_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### test/first_fit_heap_allocator_core_tb.sv
module first_fit_heap_allocator_core_tb;
  import ffha_pkg::*;

  localparam int unsigned NBLK = MAX_BLOCKS_DEF;
  localparam int unsigned HDR = HEADER_BYTES_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 60000;

  // one entry of the predicted block table
  typedef struct {
    logic [31:0] offset;
    logic [31:0] size;
    logic        is_free;
  } heap_block_t;

  typedef struct {
    logic [31:0] block_address;
    logic [1:0]  status;
  } alloc_result_t;

  // heap shadow plus queue of predicted responses
  class heap_scoreboard;
    heap_block_t   blocks[NBLK];
    int unsigned   used;
    logic [31:0]   base;
    logic [24:0]   total;
    alloc_result_t pending[$];
    int unsigned   errors;

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    function void rebuild();
      for (int i = 0; i < NBLK; i++) blocks[i] = '{0, 0, 1'b0};
      blocks[0].offset = 0;
      blocks[0].size = (total >= HDR) ? 32'(total) - HDR : 0;
      blocks[0].is_free = 1'b1;
      used = 1;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      if (idx == REG_HEAP_BASE) base = val;
      else total = val[24:0];
      rebuild();
    endfunction

    function logic [31:0] payload(int unsigned i);
      return base + blocks[i].offset + HDR;
    endfunction

    function void drop(int unsigned i);
      for (int unsigned k = i; k + 1 < used; k++) blocks[k] = blocks[k + 1];
      used--;
    endfunction

    function void merge_free();
      int unsigned i;
      i = 0;
      while (i + 1 < used) begin
        if (blocks[i].is_free && blocks[i + 1].is_free) begin
          blocks[i].size += HDR + blocks[i + 1].size;
          drop(i + 1);
        end else begin
          i++;
        end
      end
    endfunction

    // note an accepted command and predict its response
    function void note_command(logic cmd, logic [23:0] req, logic [31:0] addr);
      alloc_result_t r;
      logic [31:0] need;
      r = '{32'd0, ST_NO_MEM};
      if (cmd == CMD_ALLOC) begin
        if (req == 0) r.status = ST_IGNORED;
        else begin
          need = (32'(req) + 7) & ~32'd7;
          for (int unsigned i = 0; i < used; i++) begin
            if (blocks[i].is_free && blocks[i].size >= need) begin
              if (64'(blocks[i].size) >= 64'(need) + HDR + MIN_SPLIT && used < NBLK) begin
                for (int unsigned k = used; k > i + 1; k--) blocks[k] = blocks[k - 1];
                blocks[i + 1].offset = blocks[i].offset + HDR + need;
                blocks[i + 1].size = blocks[i].size - need - HDR;
                blocks[i + 1].is_free = 1'b1;
                used++;
                blocks[i].size = need;
              end
              blocks[i].is_free = 1'b0;
              r = '{payload(i), ST_DONE};
              break;
            end
          end
        end
      end else begin
        if (addr == 0) r.status = ST_IGNORED;
        else begin
          r.status = ST_UNKNOWN;
          for (int unsigned i = 0; i < used; i++) begin
            if (payload(i) == addr) begin
              blocks[i].is_free = 1'b1;
              merge_free();
              r.status = ST_DONE;
              break;
            end
          end
        end
      end
      pending.push_back(r);
    endfunction

    task check_response(logic [39:0] data);
      alloc_result_t exp_r;
      if (pending.size() == 0) begin
        report($sformatf("response %h with nothing pending", data));
        return;
      end
      exp_r = pending.pop_front();
      if (data[31:0] !== exp_r.block_address)
        report($sformatf("block_address %h, want %h", data[31:0], exp_r.block_address));
      if (data[33:32] !== exp_r.status)
        report($sformatf("status %0d, want %0d", data[33:32], exp_r.status));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [55:0] s_axis_tdata = '0;    // request_bytes, release_address
  logic s_axis_tuser = 1'b0;         // cmd
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;         // block_address, status
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0] cfg_data = '0;

  heap_scoreboard sb;
  logic [31:0] live_addrs[$];       // payload addresses handed out and not yet freed
  int unsigned idle_cycles = 0;
  bit hold_rx = 1'b0;               // long receiver hold-off in progress

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  first_fit_heap_allocator_core u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // sample both handshakes at the edge; predict on input, check on output
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_command(s_axis_tuser, s_axis_tdata[23:0], s_axis_tdata[55:24]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (m_axis_tdata[33:32] == ST_DONE && m_axis_tdata[31:0] != 0)
          live_addrs.push_back(m_axis_tdata[31:0]);
        sb.check_response(m_axis_tdata);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog: long stretches without any transfer end the run
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("first_fit_heap_allocator_core test failed");
      $finish;
    end
  end

  // receiver: random stall per transfer, plus the long hold-off on request
  initial begin
    int unsigned gap;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      if (hold_rx) begin
        m_axis_tready <= 1'b0;
        repeat (2000) @(posedge clk);
        hold_rx = 1'b0;
      end
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk);
    end
  end

  task automatic send_command(logic cmd, logic [23:0] req, logic [31:0] addr, bit gaps);
    int unsigned gap;
    gap = (gaps && $urandom_range(0, 2) != 0) ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata <= {addr, req};
    s_axis_tuser <= cmd;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // register write only when idle; both model and block rebuild the table
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
    live_addrs.delete();
    @(posedge clk);
  endtask

  // mostly small requests, sometimes huge; frees mostly of live blocks
  task automatic random_command(bit gaps);
    int unsigned pick;
    int unsigned k;
    logic [31:0] a;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      send_command(CMD_ALLOC, ($urandom_range(0, 9) == 0) ? 24'($urandom) :
                   24'($urandom_range(0, 600)), 32'($urandom), gaps);
    end else if (pick < 90 && live_addrs.size() != 0) begin
      k = $urandom_range(0, live_addrs.size() - 1);
      a = live_addrs[k];
      live_addrs.delete(k);
      send_command(CMD_FREE, 24'($urandom), a, gaps);
    end else begin
      a = (pick % 3 == 0) ? 32'd0 : 32'($urandom);
      send_command(CMD_FREE, 24'($urandom), a, gaps);
    end
  endtask

  initial begin
    sb = new();
    sb.base = 0;
    sb.total = 25'd65536;
    sb.rebuild();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset heap, zero size, null, unknown, no fit, double free
    send_command(CMD_ALLOC, 24'd0, 32'd0, 1'b0);
    send_command(CMD_FREE, 24'd5, 32'd0, 1'b0);
    send_command(CMD_ALLOC, 24'd1, 32'd0, 1'b0);
    send_command(CMD_ALLOC, 24'hFFFFFF, 32'd0, 1'b0);
    send_command(CMD_ALLOC, 24'd100, 32'hFFFFFFFF, 1'b0);
    send_command(CMD_FREE, 24'd0, 32'h00000010, 1'b0);
    send_command(CMD_FREE, 24'd0, 32'h00000010, 1'b0);
    send_command(CMD_FREE, 24'd0, 32'h00000011, 1'b0);
    send_command(CMD_ALLOC, 24'd65520, 32'd0, 1'b0);
    send_command(CMD_ALLOC, 24'd8, 32'd0, 1'b0);
    drain();

    // tiny heap, wrapping base, extremes of both registers
    write_reg(REG_HEAP_BYTES, 32'd64);
    write_reg(REG_HEAP_BASE, 32'hFFFFFFE0);
    send_command(CMD_ALLOC, 24'd48, 32'd0, 1'b0);
    send_command(CMD_FREE, 24'd0, 32'hFFFFFFF0, 1'b0);
    send_command(CMD_ALLOC, 24'd8, 32'd0, 1'b0);
    send_command(CMD_ALLOC, 24'd8, 32'd0, 1'b0);
    send_command(CMD_ALLOC, 24'd49, 32'd0, 1'b0);
    drain();
    write_reg(REG_HEAP_BYTES, 32'h1000000);
    write_reg(REG_HEAP_BASE, 32'h12345678);
    send_command(CMD_ALLOC, 24'hFFFFF0, 32'd0, 1'b0);
    send_command(CMD_ALLOC, 24'd1, 32'd0, 1'b0);
    drain();

    // table full: many small allocations in a large heap
    write_reg(REG_HEAP_BASE, 32'h1000);
    write_reg(REG_HEAP_BYTES, 32'd65536);
    for (int i = 0; i < 300; i++) send_command(CMD_ALLOC, 24'd8, 32'd0, i > 250);
    drain();

    // sender keeps offering while the receiver holds off
    hold_rx = 1'b1;
    for (int i = 0; i < 20; i++) random_command(1'b0);
    drain();

    // random phases with different heap settings
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(REG_HEAP_BASE, (phase == 5) ? 32'hFFFFFF00 : 32'($urandom) & ~32'd7);
      write_reg(REG_HEAP_BYTES, (phase % 2 == 0) ? 32'($urandom_range(64, 4096))
                                                : 32'($urandom_range(4096, 65536)));
      for (int i = 0; i < 250; i++) random_command(phase != 2 || i > 100);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("first_fit_heap_allocator_core test passed");
    else
      $display("first_fit_heap_allocator_core test failed");
    $finish;
  end

endmodule

### files.f
rtl/ffha_pkg.sv
rtl/first_fit_heap_allocator_core.sv
test/first_fit_heap_allocator_core_tb.sv
